// ===== sv/ipv4_trie_country_lookup_unit_macros.svh =====
// ----------------------------------------------------------------------------
// IPv4 trie country lookup assertion macros
// Concurrent assertion helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef IPV4_TRIE_COUNTRY_LOOKUP_UNIT_MACROS_SVH
`define IPV4_TRIE_COUNTRY_LOOKUP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ITCL_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("itcl assertion failed");
`define ITCL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("itcl assertion failed");
`else
`define ITCL_ASSERT(label, clk, rstn, prop)
`define ITCL_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== sv/itcl_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 trie country lookup package
// Status codes, flag bytes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itcl_pkg;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NONE   = 2'd1,
    ST_BROKEN = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  localparam logic [7:0] FLAG_VALUE = 8'hC0;
  localparam logic [7:0] FLAG_NONE  = 8'h40;

  localparam logic [1:0] LAST_LEVEL = 2'd3;
  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

  localparam logic REG_FIELD_LEN  = 1'b0;
  localparam logic REG_ENTRY_SIZE = 1'b1;

  localparam logic [3:0] FIELD_LEN_RESET  = 4'd2;
  localparam logic [7:0] ENTRY_SIZE_RESET = 8'd3;

endpackage

// ===== sv/itcl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itcl_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [0:(64'd1 << ADDR_W) - 64'd1];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ipv4_trie_country_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// IPv4 trie country lookup unit
// Byte-wide multibit trie with stride eight, loaded by write beats and walked
// by lookup beats.
// ----------------------------------------------------------------------------
// A write beat stores one byte in the trie memory when its address is in range
// and gives no result. A lookup beat walks up to four levels and returns one
// result; each level reads a flag byte and then the n bytes that follow the flag
// (n is the field length for a value, the field length - 1 for a child
// offset), and the result is registered in S_DONE once the output is free. The
// walk is paced by the single read port of the byte-wide memory, whose read
// data is registered, and by the one address adder that every address step
// shares. The block takes no new beat while a lookup is in progress.
`timescale 1ns / 1ps
`include "ipv4_trie_country_lookup_unit_macros.svh"

module ipv4_trie_country_lookup_unit
  import itcl_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [19:0] in_write_address,
  input  logic [7:0]  in_write_byte,
  input  logic [31:0] in_ip_address,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_country_value,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = MEM_ADDR_BITS;
  localparam int SW = ((AW > 16) ? AW : 16) + 1;
  localparam logic [SW-1:0] DEPTH_W = SW'(1) << AW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_RD_FLAG,
    S_CHK_FLAG,
    S_INC,
    S_RD_BYTE,
    S_GET_BYTE,
    S_DONE
  } state_t;

  state_t      state_r;
  logic [31:0] ip_r;
  logic [1:0]  level_r;
  logic [63:0] offset_r;
  logic [15:0] prod_r;
  logic [SW-1:0] rd_addr_r;
  logic [3:0]  cnt_r;
  logic [63:0] acc_r;
  logic        is_value_r;
  status_t     res_status_r;
  logic [63:0] res_value_r;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [63:0] out_value_r;
  logic [3:0]  field_len_r;
  logic [7:0]  entry_size_r;

  logic [3:0]    len;
  logic [SW-1:0] add_a;
  logic [SW-1:0] add_b;
  logic [SW-1:0] add_sum;
  logic          offset_hi_nz;
  logic [7:0]    ram_rdata;
  logic [63:0]   acc_shift;
  logic          in_beat;
  logic          wr_in_range;
  logic          ram_we;
  logic          cfg_write;

  assign len = (field_len_r > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : field_len_r;

  // The one shared adder forms the entry address and steps the read address.
  always_comb begin
    add_a = rd_addr_r;
    add_b = SW'(1);
    unique case (state_r)
      S_START: begin
        add_a = SW'(offset_r[AW-1:0]);
        add_b = SW'(prod_r);
      end
      S_CHK_FLAG: begin
        add_b = SW'(len);
      end
      default: begin
        add_b = SW'(1);
      end
    endcase
  end

  assign add_sum      = add_a + add_b;
  assign offset_hi_nz = |(offset_r >> AW);
  assign acc_shift    = {acc_r[55:0], ram_rdata};

  assign in_ready    = (state_r == S_IDLE);
  assign in_beat     = in_valid && in_ready;
  assign wr_in_range = ((33'(in_write_address)) >> AW) == 33'd0;
  assign ram_we      = in_beat && !in_func && wr_in_range;

  itcl_ram #(
    .DATA_W (8),
    .ADDR_W (AW)
  ) u_trie_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_write_address)),
    .wdata (in_write_byte),
    .raddr (rd_addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_beat && in_func) begin
            ip_r     <= in_ip_address;
            level_r  <= 2'd0;
            offset_r <= 64'd0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (offset_hi_nz) begin
            res_status_r <= ST_RANGE;
            res_value_r  <= 64'd0;
            state_r      <= S_DONE;
          end else begin
            prod_r  <= 16'(ip_r[31:24]) * 16'(entry_size_r);
            ip_r    <= {ip_r[23:0], 8'd0};
            state_r <= S_START;
          end
        end
        S_START: begin
          if (add_sum >= DEPTH_W) begin
            res_status_r <= ST_RANGE;
            res_value_r  <= 64'd0;
            state_r      <= S_DONE;
          end else begin
            rd_addr_r <= add_sum;
            state_r   <= S_RD_FLAG;
          end
        end
        S_RD_FLAG: begin
          state_r <= S_CHK_FLAG;
        end
        S_CHK_FLAG: begin
          if (ram_rdata == FLAG_VALUE) begin
            if (add_sum >= DEPTH_W) begin
              res_status_r <= ST_RANGE;
              res_value_r  <= 64'd0;
              state_r      <= S_DONE;
            end else if (len == 4'd0) begin
              res_status_r <= ST_FOUND;
              res_value_r  <= 64'd0;
              state_r      <= S_DONE;
            end else begin
              is_value_r <= 1'b1;
              acc_r      <= 64'd0;
              cnt_r      <= len;
              state_r    <= S_INC;
            end
          end else if (ram_rdata == FLAG_NONE) begin
            res_status_r <= ST_NONE;
            res_value_r  <= 64'd0;
            state_r      <= S_DONE;
          end else if (len != 4'd0 && add_sum > DEPTH_W) begin
            res_status_r <= ST_RANGE;
            res_value_r  <= 64'd0;
            state_r      <= S_DONE;
          end else if (len <= 4'd1) begin
            offset_r <= (len == 4'd0) ? 64'd0 : 64'(ram_rdata);
            if (level_r == LAST_LEVEL) begin
              res_status_r <= ST_BROKEN;
              res_value_r  <= 64'd0;
              state_r      <= S_DONE;
            end else begin
              level_r <= level_r + 2'd1;
              state_r <= S_MUL;
            end
          end else begin
            is_value_r <= 1'b0;
            acc_r      <= 64'(ram_rdata);
            cnt_r      <= len - 4'd1;
            state_r    <= S_INC;
          end
        end
        S_INC: begin
          rd_addr_r <= add_sum;
          state_r   <= S_RD_BYTE;
        end
        S_RD_BYTE: begin
          state_r <= S_GET_BYTE;
        end
        S_GET_BYTE: begin
          acc_r <= acc_shift;
          if (cnt_r == 4'd1) begin
            if (is_value_r) begin
              res_status_r <= ST_FOUND;
              res_value_r  <= acc_shift;
              state_r      <= S_DONE;
            end else begin
              offset_r <= acc_shift;
              if (level_r == LAST_LEVEL) begin
                res_status_r <= ST_BROKEN;
                res_value_r  <= 64'd0;
                state_r      <= S_DONE;
              end else begin
                level_r <= level_r + 2'd1;
                state_r <= S_MUL;
              end
            end
          end else begin
            cnt_r     <= cnt_r - 4'd1;
            rd_addr_r <= add_sum;
            state_r   <= S_RD_BYTE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_country_value = out_value_r;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_len_r  <= FIELD_LEN_RESET;
      entry_size_r <= ENTRY_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_FIELD_LEN:  field_len_r  <= pwdata[3:0];
        REG_ENTRY_SIZE: entry_size_r <= pwdata[7:0];
        default:        field_len_r  <= field_len_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIELD_LEN:  prdata = 32'(field_len_r);
      REG_ENTRY_SIZE: prdata = 32'(entry_size_r);
      default:        prdata = 32'd0;
    endcase
  end

  `ITCL_ASSERT(a_result_from_done, clk, rst_n,
               $rose(out_valid_r) |-> $past(state_r == S_DONE))
  `ITCL_ASSERT(a_value_zero_unless_found, clk, rst_n,
               (out_valid_r && out_status_r != ST_FOUND) |-> (out_value_r == 64'd0))
  `ITCL_ASSERT(a_lookup_holds_input, clk, rst_n,
               (in_valid && in_ready && in_func) |=> !in_ready)
  `ITCL_ASSERT(a_byte_count_live, clk, rst_n, (state_r == S_GET_BYTE) |-> (cnt_r != 4'd0))

endmodule
